>>> hw/rtl/obn_pkg.sv
// Shared types and constants for the octree box neighbor finder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package obn_pkg;

    localparam int CODE_W  = 30;
    localparam int COUNT_W = 5;
    localparam int CFG_W   = 4;
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd1;

    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture a box code and decode its ranges
        logic step;   // advance to the next candidate combination
        logic push;   // write a result word into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic invalid;   // the captured box code is out of range
        logic self_hit;  // the current combination is the box itself
        logic walk_end;  // the current combination is the final one
    } t_status;

endpackage

`default_nettype wire

>>> hw/rtl/obn_in_if.sv
// Input channel of the neighbor finder: one box code per word.
// Depends on obn_pkg for the field width.
`default_nettype none

interface obn_in_if
    import obn_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] box_code;

    modport source (output valid, output box_code, input ready);
    modport sink   (input valid, input box_code, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/obn_out_if.sv
// Output channel of the neighbor finder: one neighbor per word.
// Depends on obn_pkg for the field widths.
`default_nettype none

interface obn_out_if
    import obn_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [CODE_W-1:0]  neighbor_code;
    logic [COUNT_W-1:0] neighbor_count;
    logic               last;
    logic               invalid;

    modport source (output valid, output neighbor_code, output neighbor_count,
                    output last, output invalid, input ready);
    modport sink   (input valid, input neighbor_code, input neighbor_count,
                    input last, input invalid, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/obn_ctrl.sv
// Controller of the neighbor finder: sequences capture, walk and output.
// Depends on obn_pkg for the state, command and status types.
`default_nettype none

module obn_ctrl
    import obn_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_in_valid,
    output logic         o_in_ready,
    input  wire          i_out_ready,
    output logic         o_out_valid,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_WALK;
                end
            end
            S_WALK: begin
                if (i_status.invalid) begin
                    if (slot_free) begin
                        o_cmd.push = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else if (i_status.self_hit) begin
                    // The box itself is skipped without using the output slot.
                    o_cmd.step = 1'b1;
                    if (i_status.walk_end) begin
                        n_state = S_IDLE;
                    end
                end else if (slot_free) begin
                    o_cmd.push = 1'b1;
                    o_cmd.step = 1'b1;
                    if (i_status.walk_end) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (o_cmd.push) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/obn_dp.sv
// Datapath of the neighbor finder: axis decode, candidate counters,
// Morton re-interleave and the output register. Depends on obn_pkg.
`default_nettype none

module obn_dp
    import obn_pkg::*;
#(
    parameter int MAX_LEVEL = 10
) (
    input  wire                i_clk,
    input  wire t_cmd          i_cmd,
    input  wire [CODE_W-1:0]   i_box_code,
    input  wire [CFG_W-1:0]    i_cfg_level,
    output t_status            o_status,
    output logic [CODE_W-1:0]  o_nbr_code,
    output logic [COUNT_W-1:0] o_nbr_count,
    output logic               o_last,
    output logic               o_invalid
);

    localparam int AXW = MAX_LEVEL;
    localparam int LW  = $clog2(MAX_LEVEL + 1);

    logic [LW-1:0]  eff_lvl;
    logic [AXW-1:0] max_idx;
    logic           code_bad;

    // Axis 0 is x (top bit of each triple), 1 is y, 2 is z.
    logic [AXW-1:0] t_ax   [3];
    logic [AXW-1:0] lo_ax  [3];
    logic [1:0]     num_ax [3];
    logic [1:0]     off_ax [3];
    logic [AXW-1:0] cur_ax [3];
    logic [COUNT_W-1:0] total;
    logic [CODE_W-1:0]  nbr_bits;

    logic [AXW-1:0]     r_lo  [3];
    logic [1:0]         r_num [3];
    logic [1:0]         r_off [3];
    logic [1:0]         r_cnt [3];
    logic [COUNT_W-1:0] r_total;
    logic [COUNT_W-1:0] r_sent;
    logic               r_invalid;
    logic [CODE_W-1:0]  r_out_code;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_last;
    logic               r_out_inv;

    always_comb begin
        if (i_cfg_level == '0) begin
            eff_lvl = LW'(1);
        end else if (int'(i_cfg_level) > MAX_LEVEL) begin
            eff_lvl = LW'(MAX_LEVEL);
        end else begin
            eff_lvl = LW'(i_cfg_level);
        end
    end

    always_comb begin
        for (int b = 0; b < AXW; b++) begin
            max_idx[b] = (b < int'(eff_lvl));
        end
        code_bad = 1'b0;
        for (int b = 0; b < CODE_W; b++) begin
            if (i_box_code[b] && (b >= 3 * int'(eff_lvl))) begin
                code_bad = 1'b1;
            end
        end
    end

    genvar a, g;
    generate
        for (a = 0; a < 3; a++) begin : g_axis
            for (g = 0; g < AXW; g++) begin : g_bit
                if (3 * g + 2 - a < CODE_W) begin : g_in
                    assign t_ax[a][g] = i_box_code[3 * g + 2 - a];
                end else begin : g_zero
                    assign t_ax[a][g] = 1'b0;
                end
            end
        end
        for (g = 0; g < CODE_W; g++) begin : g_out
            if (g / 3 < AXW) begin : g_map
                assign nbr_bits[g] = cur_ax[2 - (g % 3)][g / 3];
            end else begin : g_zero
                assign nbr_bits[g] = 1'b0;
            end
        end
    endgenerate

    // Clipped range on each axis: first index, count and the box's own offset.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (t_ax[k] == '0) begin
                lo_ax[k]  = '0;
                num_ax[k] = 2'd2;
                off_ax[k] = 2'd0;
            end else if (t_ax[k] >= max_idx) begin
                lo_ax[k]  = max_idx - AXW'(1);
                num_ax[k] = 2'd2;
                off_ax[k] = 2'(t_ax[k] - lo_ax[k]);
            end else begin
                lo_ax[k]  = t_ax[k] - AXW'(1);
                num_ax[k] = 2'd3;
                off_ax[k] = 2'd1;
            end
            cur_ax[k] = r_lo[k] + AXW'(r_cnt[k]);
        end
        total = {3'b000, num_ax[0]} * {3'b000, num_ax[1]} * {3'b000, num_ax[2]}
                - COUNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int k = 0; k < 3; k++) begin
                r_lo[k]  <= lo_ax[k];
                r_num[k] <= num_ax[k];
                r_off[k] <= off_ax[k];
                r_cnt[k] <= 2'd0;
            end
            r_total   <= total;
            r_sent    <= '0;
            r_invalid <= code_bad;
        end else if (i_cmd.step) begin
            // z runs fastest, then y, then x.
            if (r_cnt[2] == r_num[2] - 2'd1) begin
                r_cnt[2] <= 2'd0;
                if (r_cnt[1] == r_num[1] - 2'd1) begin
                    r_cnt[1] <= 2'd0;
                    r_cnt[0] <= r_cnt[0] + 2'd1;
                end else begin
                    r_cnt[1] <= r_cnt[1] + 2'd1;
                end
            end else begin
                r_cnt[2] <= r_cnt[2] + 2'd1;
            end
        end

        if (i_cmd.push) begin
            r_sent <= r_sent + COUNT_W'(1);
            if (r_invalid) begin
                r_out_code  <= '0;
                r_out_count <= '0;
                r_out_last  <= 1'b1;
                r_out_inv   <= 1'b1;
            end else begin
                r_out_code  <= nbr_bits;
                r_out_count <= r_total;
                r_out_last  <= (r_sent + COUNT_W'(1)) == r_total;
                r_out_inv   <= 1'b0;
            end
        end
    end

    assign o_status.invalid  = r_invalid;
    assign o_status.self_hit = (r_cnt[0] == r_off[0]) && (r_cnt[1] == r_off[1])
                            && (r_cnt[2] == r_off[2]);
    assign o_status.walk_end = (r_cnt[0] == r_num[0] - 2'd1)
                            && (r_cnt[1] == r_num[1] - 2'd1)
                            && (r_cnt[2] == r_num[2] - 2'd1);

    assign o_nbr_code  = r_out_code;
    assign o_nbr_count = r_out_count;
    assign o_last      = r_out_last;
    assign o_invalid   = r_out_inv;

endmodule

`default_nettype wire

>>> hw/rtl/octree_box_neighbors.sv
// Octree box neighbor finder. An accepted box code is captured, then each candidate in
// its clipped 2..3 x 2..3 x 2..3 block (8 to 27 candidates, the box itself skipped) is
// walked; an output stall holds the walk, and no new code is taken until it ends. An
// out-of-range code gives one invalid word. The first neighbor is registered by the first
// push after capture, after a skip if the first candidate is the box itself. Synchronous
// active-low reset idles the controller, empties the output register and sets level 1.
`default_nettype none

module octree_box_neighbors
    import obn_pkg::*;
#(
    parameter int MAX_LEVEL = 10
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_cfg_we,
    input  wire [CFG_W-1:0] i_cfg_wdata,
    obn_in_if.sink          i_box,
    obn_out_if.source       o_nbr
);

    logic [CFG_W-1:0] r_tree_level;
    t_cmd             cmd;
    t_status          status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tree_level <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_tree_level <= i_cfg_wdata;
        end
    end

    obn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_box.valid),
        .o_in_ready  (i_box.ready),
        .i_out_ready (o_nbr.ready),
        .o_out_valid (o_nbr.valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    obn_dp #(
        .MAX_LEVEL (MAX_LEVEL)
    ) u_dp (
        .i_clk       (i_clk),
        .i_cmd       (cmd),
        .i_box_code  (i_box.box_code),
        .i_cfg_level (r_tree_level),
        .o_status    (status),
        .o_nbr_code  (o_nbr.neighbor_code),
        .o_nbr_count (o_nbr.neighbor_count),
        .o_last      (o_nbr.last),
        .o_invalid   (o_nbr.invalid)
    );

    // An invalid word is always the only and final word for its box.
    a_invalid_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_nbr.valid && o_nbr.invalid |-> o_nbr.last && (o_nbr.neighbor_count == '0))
        else $error("invalid word without last or with nonzero count");

    // A regular neighbor word carries a count between 7 and 26.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_nbr.valid && !o_nbr.invalid |->
            (o_nbr.neighbor_count >= COUNT_W'(7)) && (o_nbr.neighbor_count <= COUNT_W'(26)))
        else $error("neighbor count out of range");

    // In the cycle after a box is captured, the block is busy and does not accept input.
    a_busy_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_box.valid && i_box.ready |=> !i_box.ready)
        else $error("input accepted twice in a row");

endmodule

`default_nettype wire
